// ===== rtl/rfla_pkg.sv =====
// Shared types, codes and bit-search helpers of the register free-list allocator.
`timescale 1ns / 1ps

package rfla_pkg;

    // The free map is kept in RAM words of this many bits.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Request codes carried in the low bits of s_tuser.
    localparam logic [1:0] OP_ONE  = 2'd0;
    localparam logic [1:0] OP_PAIR = 2'd1;
    localparam logic [1:0] OP_FREE = 2'd2;

    // Result status codes carried in m_tuser.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [1:0] STAT_INVALID   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HINT,
        S_LOW,
        S_PAIR,
        S_PAIR_HI,
        S_FREE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] status;
    } result_t;

    // Returns {found, index} of the lowest set bit of a word.
    function automatic logic [BIT_W:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    // Returns {found, index} of the highest bit k with bits k and k+1 both set.
    // The carry stands for bit 0 of the next higher word.
    function automatic logic [BIT_W:0] highest_pair(input logic [WORD_BITS-1:0] w,
                                                    input logic carry);
        logic [WORD_BITS:0] ext;
        logic [BIT_W:0]     r;
        ext = {carry, w};
        r   = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (ext[i] && ext[i+1]) begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/rfla_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/register_free_list_allocator_core.sv =====
// Virtual register allocator with single and pair reserves and frees over a RAM-held free map.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------------
//  s_      | in  | s_tvalid / s_tready | request: opcode, register, hint
//  m_      | out | m_tvalid / m_tready | result: first, second register, status
//
// One request is handled at a time. The free map is read one 32-bit RAM word per
// cycle, and a reserve scans the map words up to the mark. A hinted reserve first
// checks the hinted register, or falls back to that scan when it is taken. A free
// at or above the mark skips the map, and a pair split across two words writes the
// upper word in the S_PAIR_HI state. After reset a clearing pass writes every map
// word before the first item is taken. A stalled result waits in the output register
// while the next item is already accepted.
`timescale 1ns / 1ps

module register_free_list_allocator_core import rfla_pkg::*; #(
    parameter int NUM_REGS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // register_number [7:0], hint_register [15:8]
    input  logic [2:0]  s_tuser,   // opcode [1:0], hint_valid [2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // first_register [7:0], second_register [15:8]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int NUM_WORDS = (NUM_REGS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int HW_W      = $clog2(NUM_REGS + 1);
    localparam int CW        = (HW_W > 8 ? HW_W : 8) + 1;

    state_t                state_reg, state_next;
    logic [7:0]            tgt_reg, tgt_next;
    logic [AW-1:0]         cidx_reg, cidx_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [HW_W-1:0]       hw_reg, hw_next;
    logic                  carry_reg, carry_next;
    logic [WORD_BITS-1:0]  prev_word_reg, prev_word_next;
    result_t               res_reg, res_next;
    result_t               m_res_reg, m_res_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  accept;
    logic [1:0]            in_opcode;
    logic                  in_hint_valid;
    logic [7:0]            in_reg_num;
    logic [7:0]            in_hint;
    logic [CW-1:0]         hw_ext;
    logic [AW-1:0]         last_word;
    logic                  hint_ok;
    logic                  free_ok;
    logic [BIT_W:0]        low_hit;
    logic [BIT_W:0]        pair_hit;
    logic [BIT_W-1:0]      tgt_bit;
    logic                  tgt_free;
    logic [CW-1:0]         base_ext;
    logic [CW-1:0]         low_num;
    logic [CW-1:0]         pair_lo;
    logic                  out_free;

    rfla_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NUM_WORDS)
    ) u_map (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign in_opcode     = s_tuser[1:0];
    assign in_hint_valid = s_tuser[2];
    assign in_reg_num    = s_tdata[7:0];
    assign in_hint       = s_tdata[15:8];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign hw_ext    = CW'(hw_reg);
    assign last_word = (hw_reg == '0) ? '0 : AW'((hw_ext - CW'(1)) >> BIT_W);
    assign hint_ok   = in_hint_valid && (CW'(in_hint) < CW'(NUM_REGS));
    assign free_ok   = CW'(in_reg_num) < hw_ext;

    // Search results on the word that the RAM delivers this cycle.
    assign low_hit  = lowest_set(ram_rdata);
    assign pair_hit = highest_pair(ram_rdata, carry_reg);
    assign tgt_bit  = tgt_reg[BIT_W-1:0];
    assign tgt_free = ram_rdata[tgt_bit];
    assign base_ext = CW'(cidx_reg) << BIT_W;
    assign low_num  = base_ext | CW'(low_hit[BIT_W-1:0]);
    assign pair_lo  = base_ext | CW'(pair_hit[BIT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            hw_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            hw_reg       <= hw_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        tgt_reg       <= tgt_next;
        cidx_reg      <= cidx_next;
        last_reg      <= last_next;
        carry_reg     <= carry_next;
        prev_word_reg <= prev_word_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == AW'(NUM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_opcode)
                        OP_ONE:  state_next = hint_ok ? S_HINT : S_LOW;
                        OP_PAIR: state_next = S_PAIR;
                        OP_FREE: state_next = free_ok ? S_FREE : S_OUT;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_HINT: begin
                state_next = tgt_free ? S_OUT : S_LOW;
            end
            S_LOW: begin
                if (low_hit[BIT_W] || cidx_reg == last_reg) begin
                    state_next = S_OUT;
                end
            end
            S_PAIR: begin
                if (pair_hit[BIT_W]) begin
                    state_next = (pair_hit[BIT_W-1:0] == BIT_W'(WORD_BITS - 1)) ?
                                 S_PAIR_HI : S_OUT;
                end else if (cidx_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_PAIR_HI: state_next = S_OUT;
            S_FREE:    state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Datapath, RAM control and result.
    always_comb begin
        tgt_next       = tgt_reg;
        cidx_next      = cidx_reg;
        last_next      = last_reg;
        clr_next       = clr_reg;
        hw_next        = hw_reg;
        carry_next     = carry_reg;
        prev_word_next = prev_word_reg;
        res_next       = res_reg;
        m_res_next     = m_res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ram_we         = 1'b0;
        ram_waddr      = cidx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = cidx_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            S_IDLE: begin
                res_next   = '{first: 8'd0, second: 8'd0, status: STAT_OK};
                last_next  = last_word;
                carry_next = 1'b0;
                if (accept) begin
                    unique case (in_opcode)
                        OP_ONE: begin
                            tgt_next = in_hint;
                            if (hint_ok) begin
                                cidx_next = AW'(CW'(in_hint) >> BIT_W);
                            end else begin
                                cidx_next = '0;
                            end
                        end
                        OP_PAIR: begin
                            cidx_next = last_word;
                        end
                        OP_FREE: begin
                            tgt_next  = in_reg_num;
                            cidx_next = AW'(CW'(in_reg_num) >> BIT_W);
                            if (!free_ok) begin
                                res_next.status = STAT_INVALID;
                            end
                        end
                        default: begin
                            res_next.status = STAT_INVALID;
                        end
                    endcase
                    ram_raddr = cidx_next;
                end
            end
            S_HINT: begin
                if (tgt_free) begin
                    ram_we                  = 1'b1;
                    ram_wdata[tgt_bit]      = 1'b0;
                    res_next.first          = tgt_reg;
                end else begin
                    cidx_next = '0;
                    ram_raddr = '0;
                end
            end
            S_LOW: begin
                if (low_hit[BIT_W]) begin
                    ram_we                          = 1'b1;
                    ram_wdata[low_hit[BIT_W-1:0]]   = 1'b0;
                    res_next.first                  = low_num[7:0];
                end else if (cidx_reg == last_reg) begin
                    if (hw_ext >= CW'(NUM_REGS)) begin
                        res_next.status = STAT_EXHAUSTED;
                    end else begin
                        res_next.first = 8'(hw_ext);
                        hw_next        = hw_reg + HW_W'(1);
                    end
                end else begin
                    cidx_next = cidx_reg + AW'(1);
                    ram_raddr = cidx_next;
                end
            end
            S_PAIR: begin
                if (pair_hit[BIT_W]) begin
                    ram_we                         = 1'b1;
                    ram_wdata[pair_hit[BIT_W-1:0]] = 1'b0;
                    // A pair inside the word also takes the next bit up; a pair
                    // across words finishes in the upper word in the S_PAIR_HI state.
                    if (pair_hit[BIT_W-1:0] != BIT_W'(WORD_BITS - 1)) begin
                        ram_wdata[pair_hit[BIT_W-1:0] + BIT_W'(1)] = 1'b0;
                    end
                    res_next.first  = pair_lo[7:0];
                    res_next.second = 8'(pair_lo + CW'(1));
                end else if (cidx_reg == '0) begin
                    if ((hw_ext + CW'(2)) > CW'(NUM_REGS)) begin
                        res_next.status = STAT_EXHAUSTED;
                    end else begin
                        res_next.first  = 8'(hw_ext);
                        res_next.second = 8'(hw_ext + CW'(1));
                        hw_next         = hw_reg + HW_W'(2);
                    end
                end else begin
                    prev_word_next = ram_rdata;
                    carry_next     = ram_rdata[0];
                    cidx_next      = cidx_reg - AW'(1);
                    ram_raddr      = cidx_next;
                end
            end
            S_PAIR_HI: begin
                ram_we       = 1'b1;
                ram_waddr    = cidx_reg + AW'(1);
                ram_wdata    = prev_word_reg;
                ram_wdata[0] = 1'b0;
            end
            S_FREE: begin
                if (tgt_free) begin
                    res_next.status = STAT_INVALID;
                end else begin
                    ram_we             = 1'b1;
                    ram_wdata[tgt_bit] = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_res_next    = res_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.second, m_res_reg.first};
    assign m_tuser  = m_res_reg.status;

endmodule

// ===== rtl/rfla_checker.sv =====
// Port-level checks of the register free-list allocator, bound to its top level.
`timescale 1ns / 1ps

module rfla_checker import rfla_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result that is not taken stays as it is.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The map clearing pass keeps the input closed right after reset.
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during reset clearing");

    // One request at a time: accepting an item closes the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // Errors and exhaustion carry no register numbers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_INVALID || m_tuser == STAT_EXHAUSTED)
        |-> m_tdata == 16'd0)
        else $error("error result with nonzero registers");

    // Only the three defined status codes appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_EXHAUSTED ||
                      m_tuser == STAT_INVALID))
        else $error("undefined status code");

endmodule

bind register_free_list_allocator_core rfla_checker u_rfla_checker (.*);

// ===== tb/sv/register_free_list_allocator_core_tb.sv =====
// Self-checking testbench for the register free-list allocator core.
`timescale 1ns / 1ps

module register_free_list_allocator_core_tb;
    import rfla_pkg::*;

    localparam int NUM_REGS = 256;

    // Opcode 3 has no meaning and must be rejected.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // register_number [7:0], hint_register [15:8]
    logic [2:0]  s_tuser;   // opcode [1:0], hint_valid [2]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // first_register [7:0], second_register [15:8]
    logic [1:0]  m_tuser;   // status [1:0]

    // Shadow copy of the allocator state, advanced on every accepted item.
    logic [NUM_REGS-1:0] shadow_free;
    int unsigned         shadow_mark;

    result_t pending_grants[$];
    result_t next_grant;
    int      mismatch_count = 0;

    // Idle controls shared by the test tasks, the sender and the receiver.
    bit      tx_idle_en = 1'b0;
    bit      rx_idle_en = 1'b0;
    int      rx_hold_len = 0;

    register_free_list_allocator_core #(
        .NUM_REGS(NUM_REGS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic result_t allocate_or_free(input logic [1:0] op, input logic [7:0] rnum,
                                                 input logic hv, input logic [7:0] hint);
        result_t     r;
        int unsigned i;
        int unsigned top;
        r = '{first: 8'd0, second: 8'd0, status: STAT_OK};
        case (op)
            OP_ONE: begin
                if (hv && hint < shadow_mark && shadow_free[hint]) begin
                    shadow_free[hint] = 1'b0;
                    r.first = hint;
                    return r;
                end
                for (i = 0; i < shadow_mark && i < NUM_REGS; i++) begin
                    if (shadow_free[i]) begin
                        shadow_free[i] = 1'b0;
                        r.first = i[7:0];
                        return r;
                    end
                end
                if (shadow_mark >= NUM_REGS) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    r.first = shadow_mark[7:0];
                    shadow_mark++;
                end
            end
            OP_PAIR: begin
                top = (shadow_mark < NUM_REGS) ? shadow_mark : NUM_REGS;
                // The search runs downward so the highest free pair wins.
                for (i = top; i >= 2; i--) begin
                    if (shadow_free[i-1] && shadow_free[i-2]) begin
                        shadow_free[i-1] = 1'b0;
                        shadow_free[i-2] = 1'b0;
                        r.first  = 8'(i - 2);
                        r.second = 8'(i - 1);
                        return r;
                    end
                end
                if (shadow_mark + 2 > NUM_REGS) begin
                    r.status = STAT_EXHAUSTED;
                end else begin
                    r.first  = shadow_mark[7:0];
                    r.second = 8'(shadow_mark + 1);
                    shadow_mark += 2;
                end
            end
            OP_FREE: begin
                if (rnum >= shadow_mark || shadow_free[rnum]) begin
                    r.status = STAT_INVALID;
                end else begin
                    shadow_free[rnum] = 1'b1;
                end
            end
            default: r.status = STAT_INVALID;
        endcase
        return r;
    endfunction

    // Returns a register below the mark whose free bit equals want_free, or -1.
    function automatic int pick_register(input bit want_free);
        int start;
        int idx;
        int k;
        if (shadow_mark == 0) begin
            return -1;
        end
        start = $urandom_range(0, shadow_mark - 1);
        for (k = 0; k < shadow_mark; k++) begin
            idx = (start + k) % shadow_mark;
            if (shadow_free[idx] == want_free) begin
                return idx;
            end
        end
        return -1;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return $urandom_range(1, 3);
        end else if (roll < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_request(input logic [1:0] op, input logic [7:0] rnum,
                                input logic hv, input logic [7:0] hint);
        int      gap;
        result_t grant;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hint, rnum};
        s_tuser  <= {hv, op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        grant = allocate_or_free(op, rnum, hv, hint);
        pending_grants = {pending_grants, grant};
    endtask

    task automatic send_random_request();
        logic [1:0] op;
        logic [7:0] rnum;
        logic [7:0] hint;
        logic       hv;
        int         sel;
        int         pick;
        sel  = $urandom_range(0, 99);
        rnum = 8'($urandom);
        hint = 8'($urandom);
        hv   = 1'($urandom_range(0, 1));
        if (sel < 33) begin
            op = OP_ONE;
            // Point most hints at a free register so the hinted path gets hit.
            if (hv && $urandom_range(0, 2) != 0) begin
                pick = pick_register(1'b1);
                if (pick >= 0) hint = pick[7:0];
            end
        end else if (sel < 48) begin
            op = OP_PAIR;
        end else if (sel < 95) begin
            op = OP_FREE;
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                pick = pick_register(1'b0);
                if (pick >= 0) rnum = pick[7:0];
            end else if (sel < 8) begin
                pick = pick_register(1'b1);
                if (pick >= 0) rnum = pick[7:0];
            end
        end else begin
            op = OP_UNUSED;
        end
        send_request(op, rnum, hv, hint);
    endtask

    task automatic test_corner_cases();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_request(OP_FREE,   8'd0,   1'b0, 8'd0);    // free at the mark
        send_request(OP_ONE,    8'd0,   1'b1, 8'hFF);   // hint above the mark
        send_request(OP_PAIR,   8'd0,   1'b0, 8'd0);
        send_request(OP_ONE,    8'd0,   1'b0, 8'd0);
        send_request(OP_UNUSED, 8'hFF,  1'b1, 8'hFF);
        send_request(OP_FREE,   8'd1,   1'b0, 8'd0);
        send_request(OP_FREE,   8'd1,   1'b0, 8'd0);    // double free
        send_request(OP_FREE,   8'd2,   1'b0, 8'd0);
        send_request(OP_PAIR,   8'd0,   1'b0, 8'd0);    // reuses the freed pair
        send_request(OP_FREE,   8'd0,   1'b0, 8'd0);
        send_request(OP_FREE,   8'd3,   1'b0, 8'd0);
        send_request(OP_FREE,   8'd2,   1'b0, 8'd0);
        send_request(OP_ONE,    8'd0,   1'b1, 8'd3);    // hinted register is free
        send_request(OP_ONE,    8'd0,   1'b1, 8'd1);    // hinted register is taken
        send_request(OP_PAIR,   8'd0,   1'b0, 8'd0);    // lone free register, no pair
        send_request(OP_FREE,   8'hFF,  1'b0, 8'hFF);   // far above the mark
        send_request(OP_ONE,    8'hFF,  1'b0, 8'd2);
        send_request(OP_FREE,   8'd5,   1'b0, 8'd0);
        send_request(OP_FREE,   8'd4,   1'b0, 8'd0);
        send_request(OP_PAIR,   8'd0,   1'b0, 8'd0);
    endtask

    task automatic test_output_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_len = 400;
        repeat (30) send_random_request();
    endtask

    task automatic test_random_traffic(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_random_request();
        // A stretch with no idling on either side.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count / 8) send_random_request();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_exhaustion();
        while (shadow_mark + 2 <= NUM_REGS || |(shadow_free & (shadow_free >> 1))) begin
            send_request(OP_PAIR, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
        end
        send_request(OP_PAIR, 8'd0, 1'b0, 8'd0);
        while (shadow_mark < NUM_REGS || |shadow_free) begin
            send_request(OP_ONE, 8'($urandom), 1'b0, 8'($urandom));
        end
        send_request(OP_ONE,  8'd0, 1'b0, 8'd0);
        send_request(OP_ONE,  8'd0, 1'b1, 8'd7);
        send_request(OP_PAIR, 8'd0, 1'b0, 8'd0);
        send_request(OP_FREE, 8'd31, 1'b0, 8'd0);
        send_request(OP_FREE, 8'd32, 1'b0, 8'd0);
        send_request(OP_PAIR, 8'd0, 1'b0, 8'd0);     // pair across a word boundary
        send_request(OP_FREE, 8'hFF, 1'b0, 8'd0);
        send_request(OP_FREE, 8'hFF, 1'b0, 8'd0);
        send_request(OP_ONE,  8'd0, 1'b1, 8'hFF);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        shadow_free = '0;
        shadow_mark = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_cases();
        test_output_backpressure();
        test_random_traffic(450);
        test_exhaustion();
        test_random_traffic(560);
        s_tvalid <= 1'b0;
        rx_idle_en = 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pending_grants.size() != 0) begin
            note_mismatch("results still outstanding at the end");
        end
        if (mismatch_count == 0) begin
            $display("PASS register_free_list_allocator_core");
        end else begin
            $display("FAIL register_free_list_allocator_core");
        end
        $finish;
    end

    // The receiver: random stalls, plus one long hold-off on request.
    initial begin : result_ready_gen
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                note_mismatch($sformatf("unexpected result first=%0d second=%0d status=%0d",
                                        m_tdata[7:0], m_tdata[15:8], m_tuser));
            end else begin
                next_grant = pending_grants.pop_front();
                if (m_tdata[7:0] !== next_grant.first || m_tdata[15:8] !== next_grant.second ||
                    m_tuser !== next_grant.status) begin
                    note_mismatch($sformatf(
                        "expected first=%0d second=%0d status=%0d, got %0d %0d %0d",
                        next_grant.first, next_grant.second, next_grant.status,
                        m_tdata[7:0], m_tdata[15:8], m_tuser));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL register_free_list_allocator_core");
        $finish;
    end

endmodule
